// ===== rtl/aabbrt_pkg.sv =====
// ----------------------------------------------------------------------------
// aabbrt_pkg
// Shared widths, register indexes and types of the box rotate/translate refit
// pipeline.
// ----------------------------------------------------------------------------
package aabbrt_pkg;

   // Field and operand widths
   localparam int FIELD_W         = 32;
   localparam int QUAT_W          = 32;
   localparam int NUM_AXES        = 3;
   localparam int NUM_CORNERS     = 8;
   localparam int BOX_DATA_W      = 2 * NUM_AXES * FIELD_W;
   localparam int COORD_WIDTH_DEF = 32;
   localparam int REG_IDX_W       = 3;

   // Internal arithmetic widths
   localparam int PROD_W  = FIELD_W + QUAT_W;        // q * v, exact
   localparam int C_SHIFT = 30;                      // q x v scale back
   localparam int C_W     = PROD_W + 1 - C_SHIFT;    // rounded q x v
   localparam int D_SHIFT = 29;                      // 2 q x c and 2 w c scale back
   localparam int QC_W    = QUAT_W + C_W;            // q * c, exact
   localparam int D_W     = QC_W + 1 - D_SHIFT;      // rounded 2 q x c
   localparam int E_W     = QC_W - D_SHIFT;          // rounded 2 w c
   localparam int SUM_W   = D_W + 3;                 // v + e + d + t, exact

   // Configuration register indexes
   typedef enum logic [REG_IDX_W-1:0] {
      REG_ROT_W  = 3'd0,
      REG_ROT_X  = 3'd1,
      REG_ROT_Y  = 3'd2,
      REG_ROT_Z  = 3'd3,
      REG_MOVE_X = 3'd4,
      REG_MOVE_Y = 3'd5,
      REG_MOVE_Z = 3'd6
   } reg_idx_type;

   localparam logic [QUAT_W-1:0] ROT_W_RESET = 32'h4000_0000;

   typedef logic signed [FIELD_W-1:0] coord_type;
   typedef logic signed [QUAT_W-1:0]  quat_type;
   typedef logic signed [PROD_W-1:0]  prod_type;

   // Stage load enables handed to each corner datapath
   typedef struct packed {
      logic s3;
      logic s4;
      logic s5;
      logic s6;
   } corner_en_type;

endpackage

// ===== rtl/aabb_rotate_translate_refit_unit.sv =====
// The path from the edge that accepts a req transaction to rsp_tvalid holds
// eight register stages.
// Throughput: one box per cycle; eight corner datapaths run side by side and
// every stage holds at most one 32x35 multiply or one wide add and compare.
// A stall on rsp_tready holds only the stages that are full; bubbles close up.
// Reset (synchronous, active high) clears all valid bits, sets the rotation
// to the identity quaternion and the translation to zero.
// ----------------------------------------------------------------------------
// aabb_rotate_translate_refit_unit
// Rotates the eight corners of a box by a quaternion, translates them and
// returns the axis-aligned box that encloses them.
// ----------------------------------------------------------------------------
module aabb_rotate_translate_refit_unit #(
   parameter int COORD_WIDTH = aabbrt_pkg::COORD_WIDTH_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [aabbrt_pkg::BOX_DATA_W-1:0]     req_tdata,
   // out_min_x, out_min_y, out_min_z, out_max_x, out_max_y, out_max_z
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [aabbrt_pkg::BOX_DATA_W-1:0]     rsp_tdata,
   // saturated
   output logic                                  rsp_tuser,
   input  logic                                  csr_we,
   input  logic [aabbrt_pkg::REG_IDX_W-1:0]      csr_addr,
   input  logic [aabbrt_pkg::FIELD_W-1:0]        csr_wdata
);
   import aabbrt_pkg::*;

   localparam int CW       = (COORD_WIDTH < FIELD_W) ? COORD_WIDTH : FIELD_W;
   localparam int CW_SHIFT = FIELD_W - CW;
   localparam int NUM_STG  = 8;

   function automatic coord_type sext_coord(logic [FIELD_W-1:0] raw);
      sext_coord = coord_type'($signed(raw << CW_SHIFT) >>> CW_SHIFT);
   endfunction

   // Configuration registers
   quat_type      rot_w_ff;
   quat_type      rot_xyz_ff [3];
   logic [FIELD_W-1:0] move_ff [3];
   coord_type     move_sx [3];

   // Pipeline control
   logic [NUM_STG:1] valid_ff;
   logic [NUM_STG:1] valid_in;
   logic [NUM_STG:1] stage_en;
   corner_en_type    corner_en;

   // Stage 1 and 2 payload
   coord_type box_in  [2][3];
   coord_type box1_ff [2][3];
   coord_type box2_ff [2][3];
   prod_type  pa_in   [2][3];
   prod_type  pb_in   [2][3];
   prod_type  pa_ff   [2][3];
   prod_type  pb_ff   [2][3];

   // Corner outputs and reduction
   coord_type corner_coord [NUM_CORNERS][3];
   logic [NUM_CORNERS-1:0] corner_sat;
   coord_type min7_in [3][2];
   coord_type max7_in [3][2];
   coord_type min7_ff [3][2];
   coord_type max7_ff [3][2];
   coord_type min4    [3][4];
   coord_type max4    [3][4];
   logic      sat7_ff;
   coord_type min8_in [3];
   coord_type max8_in [3];
   coord_type min8_ff [3];
   coord_type max8_ff [3];
   logic      sat8_ff;

   // Write configuration registers; unknown indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         rot_w_ff   <= ROT_W_RESET;
         rot_xyz_ff <= '{default: '0};
         move_ff    <= '{default: '0};
      end else if (csr_we) begin
         unique case (reg_idx_type'(csr_addr))
            REG_ROT_W:  rot_w_ff      <= csr_wdata;
            REG_ROT_X:  rot_xyz_ff[0] <= csr_wdata;
            REG_ROT_Y:  rot_xyz_ff[1] <= csr_wdata;
            REG_ROT_Z:  rot_xyz_ff[2] <= csr_wdata;
            REG_MOVE_X: move_ff[0]    <= csr_wdata;
            REG_MOVE_Y: move_ff[1]    <= csr_wdata;
            REG_MOVE_Z: move_ff[2]    <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Stage load enables: a stage loads when empty or when its successor loads
   always_comb begin
      stage_en[NUM_STG] = ~valid_ff[NUM_STG] | rsp_tready;
      for (int k = NUM_STG - 1; k >= 1; k--) begin
         stage_en[k] = ~valid_ff[k] | stage_en[k + 1];
      end
      valid_in[1] = req_tvalid;
      for (int k = 2; k <= NUM_STG; k++) begin
         valid_in[k] = valid_ff[k - 1];
      end
   end

   assign req_tready = stage_en[1];
   assign corner_en  = '{s3: stage_en[3], s4: stage_en[4], s5: stage_en[5],
                         s6: stage_en[6]};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int k = 1; k <= NUM_STG; k++) begin
            if (stage_en[k]) valid_ff[k] <= valid_in[k];
         end
      end
   end

   // Unpack the box, narrow to the coordinate width
   for (genvar i = 0; i < 3; i++) begin : g_unpack
      assign box_in[0][i] = sext_coord(req_tdata[i*FIELD_W +: FIELD_W]);
      assign box_in[1][i] = sext_coord(req_tdata[(i+3)*FIELD_W +: FIELD_W]);
      assign move_sx[i]   = sext_coord(move_ff[i]);
   end

   // Cross product terms of q x v, shared by the corners
   for (genvar m = 0; m < 2; m++) begin : g_side
      for (genvar i = 0; i < 3; i++) begin : g_term
         assign pa_in[m][i] = rot_xyz_ff[(i + 1) % 3] * box1_ff[m][(i + 2) % 3];
         assign pb_in[m][i] = rot_xyz_ff[(i + 2) % 3] * box1_ff[m][(i + 1) % 3];
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[1]) box1_ff <= box_in;
      if (stage_en[2]) begin
         box2_ff <= box1_ff;
         pa_ff   <= pa_in;
         pb_ff   <= pb_in;
      end
   end

   // Eight corner datapaths; corner bit i picks max on axis i
   for (genvar k = 0; k < NUM_CORNERS; k++) begin : g_corner
      prod_type  sel_pa [3];
      prod_type  sel_pb [3];
      coord_type sel_v  [3];
      for (genvar i = 0; i < 3; i++) begin : g_sel
         assign sel_pa[i] = pa_ff[(k >> ((i + 2) % 3)) & 1][i];
         assign sel_pb[i] = pb_ff[(k >> ((i + 1) % 3)) & 1][i];
         assign sel_v[i]  = box2_ff[(k >> i) & 1][i];
      end

      aabbrt_corner #(
         .COORD_WIDTH (COORD_WIDTH)
      ) u_corner (
         .clock     (clock),
         .stage_en  (corner_en),
         .rot_w     (rot_w_ff),
         .rot_xyz   (rot_xyz_ff),
         .move_xyz  (move_sx),
         .prod_a    (sel_pa),
         .prod_b    (sel_pb),
         .vert      (sel_v),
         .coord_out (corner_coord[k]),
         .sat_out   (corner_sat[k])
      );
   end

   // Reduce eight corners to two per axis
   always_comb begin
      for (int a = 0; a < 3; a++) begin
         for (int p = 0; p < 4; p++) begin
            min4[a][p] = (corner_coord[2*p+1][a] < corner_coord[2*p][a]) ?
                         corner_coord[2*p+1][a] : corner_coord[2*p][a];
            max4[a][p] = (corner_coord[2*p+1][a] > corner_coord[2*p][a]) ?
                         corner_coord[2*p+1][a] : corner_coord[2*p][a];
         end
         for (int p = 0; p < 2; p++) begin
            min7_in[a][p] = (min4[a][2*p+1] < min4[a][2*p]) ?
                            min4[a][2*p+1] : min4[a][2*p];
            max7_in[a][p] = (max4[a][2*p+1] > max4[a][2*p]) ?
                            max4[a][2*p+1] : max4[a][2*p];
         end
      end
   end

   // Final compare into the output register
   always_comb begin
      for (int a = 0; a < 3; a++) begin
         min8_in[a] = (min7_ff[a][1] < min7_ff[a][0]) ? min7_ff[a][1] : min7_ff[a][0];
         max8_in[a] = (max7_ff[a][1] > max7_ff[a][0]) ? max7_ff[a][1] : max7_ff[a][0];
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[7]) begin
         min7_ff <= min7_in;
         max7_ff <= max7_in;
         sat7_ff <= |corner_sat;
      end
      if (stage_en[8]) begin
         min8_ff <= min8_in;
         max8_ff <= max8_in;
         sat8_ff <= sat7_ff;
      end
   end

   assign rsp_tvalid = valid_ff[NUM_STG];
   assign rsp_tdata  = {max8_ff[2], max8_ff[1], max8_ff[0],
                        min8_ff[2], min8_ff[1], min8_ff[0]};
   assign rsp_tuser  = sat8_ff;

endmodule

// ===== rtl/aabbrt_corner.sv =====
// ----------------------------------------------------------------------------
// aabbrt_corner
// Datapath of one box corner: finishes q x v, forms 2 q x c and 2 w c, adds
// the corner and the translation, and clamps to the coordinate range.
// ----------------------------------------------------------------------------
module aabbrt_corner #(
   parameter int COORD_WIDTH = aabbrt_pkg::COORD_WIDTH_DEF
) (
   input  logic                      clock,
   input  aabbrt_pkg::corner_en_type stage_en,
   input  aabbrt_pkg::quat_type      rot_w,
   input  aabbrt_pkg::quat_type      rot_xyz   [3],
   input  aabbrt_pkg::coord_type     move_xyz  [3],
   input  aabbrt_pkg::prod_type      prod_a    [3],
   input  aabbrt_pkg::prod_type      prod_b    [3],
   input  aabbrt_pkg::coord_type     vert      [3],
   output aabbrt_pkg::coord_type     coord_out [3],
   output logic                      sat_out
);
   import aabbrt_pkg::*;

   localparam int CW = (COORD_WIDTH < FIELD_W) ? COORD_WIDTH : FIELD_W;
   localparam logic signed [SUM_W-1:0] CLAMP_HI =
      SUM_W'((64'sd1 <<< (CW - 1)) - 64'sd1);
   localparam logic signed [SUM_W-1:0] CLAMP_LO = ~CLAMP_HI;

   localparam logic signed [PROD_W:0] C_HALF = (PROD_W+1)'(64'sd1 <<< (C_SHIFT - 1));
   localparam logic signed [QC_W:0]   D_HALF = (QC_W+1)'(64'sd1 <<< (D_SHIFT - 1));

   logic signed [PROD_W:0]  c_diff [3];
   logic signed [C_W-1:0]   c_in   [3];
   logic signed [C_W-1:0]   c_ff   [3];
   coord_type               vert3_ff [3];

   logic signed [QC_W-1:0]  qca_in [3];
   logic signed [QC_W-1:0]  qcb_in [3];
   logic signed [QC_W-1:0]  wc_in  [3];
   logic signed [QC_W-1:0]  qca_ff [3];
   logic signed [QC_W-1:0]  qcb_ff [3];
   logic signed [QC_W-1:0]  wc_ff  [3];
   coord_type               vert4_ff [3];

   logic signed [QC_W:0]    d_diff [3];
   logic signed [QC_W-1:0]  e_sum  [3];
   logic signed [D_W-1:0]   d_in   [3];
   logic signed [E_W-1:0]   e_in   [3];
   logic signed [D_W-1:0]   d_ff   [3];
   logic signed [E_W-1:0]   e_ff   [3];
   coord_type               vert5_ff [3];

   logic signed [SUM_W-1:0] total  [3];
   coord_type               coord_in [3];
   logic [2:0]              sat_axis;
   coord_type               coord_ff [3];
   logic                    sat_ff;

   for (genvar i = 0; i < 3; i++) begin : g_axis
      // Round q x v half up, drop 30 fraction bits
      assign c_diff[i] = (PROD_W+1)'(prod_a[i]) - (PROD_W+1)'(prod_b[i]) + C_HALF;
      assign c_in[i]   = c_diff[i][PROD_W:C_SHIFT];

      // Products of q x c and w c
      assign qca_in[i] = rot_xyz[(i + 1) % 3] * c_ff[(i + 2) % 3];
      assign qcb_in[i] = rot_xyz[(i + 2) % 3] * c_ff[(i + 1) % 3];
      assign wc_in[i]  = rot_w * c_ff[i];

      // Round both terms half up, drop 29 fraction bits (doubles them)
      assign d_diff[i] = (QC_W+1)'(qca_ff[i]) - (QC_W+1)'(qcb_ff[i]) + D_HALF;
      assign d_in[i]   = d_diff[i][QC_W:D_SHIFT];
      assign e_sum[i]  = wc_ff[i] + QC_W'(D_HALF);
      assign e_in[i]   = e_sum[i][QC_W-1:D_SHIFT];

      // Move the corner and clamp to the coordinate range
      assign total[i] = SUM_W'(vert5_ff[i]) + SUM_W'(e_ff[i]) + SUM_W'(d_ff[i])
                        + SUM_W'(move_xyz[i]);
      always_comb begin
         priority if (total[i] > CLAMP_HI) begin
            coord_in[i] = CLAMP_HI[FIELD_W-1:0];
            sat_axis[i] = 1'b1;
         end else if (total[i] < CLAMP_LO) begin
            coord_in[i] = CLAMP_LO[FIELD_W-1:0];
            sat_axis[i] = 1'b1;
         end else begin
            coord_in[i] = total[i][FIELD_W-1:0];
            sat_axis[i] = 1'b0;
         end
      end
   end

   // Advance each stage when the top level lets it load
   always_ff @(posedge clock) begin
      if (stage_en.s3) begin
         c_ff     <= c_in;
         vert3_ff <= vert;
      end
      if (stage_en.s4) begin
         qca_ff   <= qca_in;
         qcb_ff   <= qcb_in;
         wc_ff    <= wc_in;
         vert4_ff <= vert3_ff;
      end
      if (stage_en.s5) begin
         d_ff     <= d_in;
         e_ff     <= e_in;
         vert5_ff <= vert4_ff;
      end
      if (stage_en.s6) begin
         coord_ff <= coord_in;
         sat_ff   <= |sat_axis;
      end
   end

   assign coord_out = coord_ff;
   assign sat_out   = sat_ff;

endmodule

// ===== rtl/aabbrt_checker.sv =====
// ----------------------------------------------------------------------------
// aabbrt_checker
// Port-level checks of the box refit unit, bound to its top level.
// ----------------------------------------------------------------------------
module aabbrt_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_tready,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [aabbrt_pkg::BOX_DATA_W-1:0] rsp_tdata,
   input logic                              rsp_tuser
);
   import aabbrt_pkg::*;

   // No result directly after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result transaction right after reset");

   // Hold a stalled result transaction
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result transaction changed");

   // A ready sink never back-pressures the input
   a_no_backpressure: assert property (@(posedge clock) disable iff (reset)
      rsp_tready |-> req_tready)
      else $error("input stalled while result side is ready");

   // Minimum over the corners never exceeds the maximum
   a_min_le_max: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |->
         ($signed(rsp_tdata[FIELD_W-1:0]) <= $signed(rsp_tdata[4*FIELD_W-1:3*FIELD_W])) &&
         ($signed(rsp_tdata[2*FIELD_W-1:FIELD_W]) <=
          $signed(rsp_tdata[5*FIELD_W-1:4*FIELD_W])) &&
         ($signed(rsp_tdata[3*FIELD_W-1:2*FIELD_W]) <=
          $signed(rsp_tdata[6*FIELD_W-1:5*FIELD_W])))
      else $error("result box min above max");

endmodule

bind aabb_rotate_translate_refit_unit aabbrt_checker u_aabbrt_checker (.*);

// ===== tb/sv/tb_aabb_rotate_translate_refit_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_aabb_rotate_translate_refit_unit
// Streams boxes through the rotate/translate refit unit under several rotation
// and translation settings. Each box is predicted in the bench (eight corners,
// rounded cross products, clamping) and every response transaction is
// compared field by field. Both stream sides idle in random bursts, and one
// long response hold-off fills the pipeline and stalls the request side.
// ----------------------------------------------------------------------------
module tb_aabb_rotate_translate_refit_unit;
   import aabbrt_pkg::*;

   localparam int LATENCY     = 8;
   localparam int CYCLE_LIMIT = 300000;
   localparam int NUM_REGS    = 7;
   localparam logic [REG_IDX_W-1:0] REG_UNUSED = 3'd7;
   localparam coord_type COORD_MAX = 32'sh7FFF_FFFF;
   localparam coord_type COORD_MIN = 32'sh8000_0000;

   // Box layout on the stream: min_x in the lowest bits
   typedef struct packed {
      coord_type max_z;
      coord_type max_y;
      coord_type max_x;
      coord_type min_z;
      coord_type min_y;
      coord_type min_x;
   } box_t;

   typedef struct {
      box_t box;
      logic sat;
   } refit_t;

   typedef logic signed [127:0] wide_t;

   typedef struct {
      wide_t x;
      wide_t y;
      wide_t z;
   } vec_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [BOX_DATA_W-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [BOX_DATA_W-1:0] rsp_tdata;
   logic rsp_tuser;
   logic csr_we = 1'b0;
   logic [REG_IDX_W-1:0] csr_addr = REG_ROT_W;
   logic [FIELD_W-1:0] csr_wdata = '0;

   // Bench copy of the configuration registers and of the pending results
   logic [31:0] xform_reg [NUM_REGS];
   logic [31:0] cfg_next [NUM_REGS];
   refit_t refit_expect_q [$];

   int error_count = 0;
   int cycle_count = 0;
   int req_gap_pct = 0;
   int rsp_stall_pct = 0;
   int rsp_hold_req = 0;

   aabb_rotate_translate_refit_unit DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   // Clock and run limit
   initial begin
      forever #2 clock = ~clock;
   end

   initial begin
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Prediction
   // ------------------------------------------------------------------------

   // Round half up, then arithmetic shift right
   function automatic wide_t round_shift(wide_t a, int s);
      return (a + (wide_t'(1) <<< (s - 1))) >>> s;
   endfunction

   function automatic vec_t cross_rounded(vec_t a, vec_t b, int s);
      vec_t o;
      o.x = round_shift(a.y * b.z - a.z * b.y, s);
      o.y = round_shift(a.z * b.x - a.x * b.z, s);
      o.z = round_shift(a.x * b.y - a.y * b.x, s);
      return o;
   endfunction

   function automatic coord_type clamp_coord(input wide_t s, inout logic sat);
      if (s > wide_t'(COORD_MAX)) begin
         sat = 1'b1;
         return COORD_MAX;
      end
      if (s < wide_t'(COORD_MIN)) begin
         sat = 1'b1;
         return COORD_MIN;
      end
      return coord_type'(s);
   endfunction

   // Move all eight corners and take the enclosing box
   function automatic refit_t predict_refit(box_t b);
      refit_t r;
      vec_t q, v, c, d;
      wide_t w;
      coord_type pos [3];
      coord_type lo [3];
      coord_type hi [3];
      w   = wide_t'($signed(xform_reg[REG_ROT_W]));
      q.x = wide_t'($signed(xform_reg[REG_ROT_X]));
      q.y = wide_t'($signed(xform_reg[REG_ROT_Y]));
      q.z = wide_t'($signed(xform_reg[REG_ROT_Z]));
      r.sat = 1'b0;
      for (int k = 0; k < NUM_CORNERS; k++) begin
         v.x = wide_t'(k[0] ? b.max_x : b.min_x);
         v.y = wide_t'(k[1] ? b.max_y : b.min_y);
         v.z = wide_t'(k[2] ? b.max_z : b.min_z);
         c = cross_rounded(q, v, C_SHIFT);
         d = cross_rounded(q, c, D_SHIFT);
         pos[0] = clamp_coord(v.x + round_shift(w * c.x, D_SHIFT) + d.x
                              + wide_t'($signed(xform_reg[REG_MOVE_X])), r.sat);
         pos[1] = clamp_coord(v.y + round_shift(w * c.y, D_SHIFT) + d.y
                              + wide_t'($signed(xform_reg[REG_MOVE_Y])), r.sat);
         pos[2] = clamp_coord(v.z + round_shift(w * c.z, D_SHIFT) + d.z
                              + wide_t'($signed(xform_reg[REG_MOVE_Z])), r.sat);
         for (int i = 0; i < NUM_AXES; i++) begin
            if (k == 0 || pos[i] < lo[i]) lo[i] = pos[i];
            if (k == 0 || pos[i] > hi[i]) hi[i] = pos[i];
         end
      end
      r.box.min_x = lo[0];
      r.box.min_y = lo[1];
      r.box.min_z = lo[2];
      r.box.max_x = hi[0];
      r.box.max_y = hi[1];
      r.box.max_z = hi[2];
      return r;
   endfunction

   // ------------------------------------------------------------------------
   // Shared driving tasks
   // ------------------------------------------------------------------------

   // Offer one box, optionally after a gap; record the expectation on accept
   task automatic send_box(input box_t b);
      int gap;
      if (req_gap_pct != 0 && $urandom_range(0, 99) < req_gap_pct) begin
         gap = $urandom_range(1, 10);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      do @(negedge clock); while (!req_tready);
      refit_expect_q.push_back(predict_refit(b));
      @(posedge clock);
   endtask

   // Write all registers from cfg_next, optionally poke the unused index too
   task automatic apply_config(input bit poke_unused);
      for (int i = 0; i < NUM_REGS; i++) begin
         csr_we    <= 1'b1;
         csr_addr  <= reg_idx_type'(i);
         csr_wdata <= cfg_next[i];
         @(posedge clock);
         xform_reg[i] = cfg_next[i];
      end
      if (poke_unused) begin
         csr_addr  <= REG_UNUSED;
         csr_wdata <= $urandom;
         @(posedge clock);
      end
      csr_we <= 1'b0;
   endtask

   // Drop valid and wait until every expected result has come out
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (refit_expect_q.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   function automatic box_t make_box(coord_type nx, coord_type ny, coord_type nz,
                                     coord_type xx, coord_type xy, coord_type xz);
      box_t b;
      b.min_x = nx;
      b.min_y = ny;
      b.min_z = nz;
      b.max_x = xx;
      b.max_y = xy;
      b.max_z = xz;
      return b;
   endfunction

   // Style 0: small coordinates, 1: full range, else field extremes
   function automatic coord_type rand_coord(int style);
      if (style == 0) return $urandom_range(0, 2 ** 21) - 2 ** 20;
      if (style == 1) return $urandom;
      case ($urandom_range(0, 3))
         0: return COORD_MAX;
         1: return COORD_MIN;
         2: return 32'sd0;
         default: return -32'sd1;
      endcase
   endfunction

   // Mostly ordered boxes; a quarter keep whatever order they came in
   function automatic box_t rand_box(int style);
      coord_type lo [3];
      coord_type hi [3];
      coord_type tmp;
      for (int i = 0; i < NUM_AXES; i++) begin
         lo[i] = rand_coord(style);
         hi[i] = rand_coord(style);
         if ($urandom_range(0, 3) != 0 && lo[i] > hi[i]) begin
            tmp   = lo[i];
            lo[i] = hi[i];
            hi[i] = tmp;
         end
      end
      return make_box(lo[0], lo[1], lo[2], hi[0], hi[1], hi[2]);
   endfunction

   // Style 0/1: unit rotation, 2: arbitrary registers, else extremes
   task automatic pick_config(input int style);
      real qa [4];
      real n;
      if (style <= 1) begin
         n = 0.0;
         for (int i = 0; i < 4; i++) begin
            qa[i] = $urandom_range(0, 2000) - 1000.0;
            n = n + qa[i] * qa[i];
         end
         n = $sqrt(n);
         for (int i = 0; i < 4; i++)
            cfg_next[i] = (n < 1.0) ? ((i == 0) ? ROT_W_RESET : 32'd0)
                                    : $rtoi(qa[i] / n * 1073741823.0);
      end else begin
         for (int i = 0; i < 4; i++)
            cfg_next[i] = (style == 2) ? $urandom : rand_coord(3);
      end
      for (int i = 4; i < NUM_REGS; i++)
         cfg_next[i] = (style == 0) ? rand_coord(0) : rand_coord(style == 3 ? 3 : 1);
   endtask

   task automatic set_config(input logic [31:0] rw, input logic [31:0] rx,
                             input logic [31:0] ry, input logic [31:0] rz,
                             input logic [31:0] mx, input logic [31:0] my,
                             input logic [31:0] mz, input bit poke_unused);
      cfg_next[REG_ROT_W]  = rw;
      cfg_next[REG_ROT_X]  = rx;
      cfg_next[REG_ROT_Y]  = ry;
      cfg_next[REG_ROT_Z]  = rz;
      cfg_next[REG_MOVE_X] = mx;
      cfg_next[REG_MOVE_Y] = my;
      cfg_next[REG_MOVE_Z] = mz;
      apply_config(poke_unused);
   endtask

   // ------------------------------------------------------------------------
   // Response side: random stalls and the requested long hold-off
   // ------------------------------------------------------------------------
   initial begin
      int stall_left;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (rsp_hold_req != 0) begin
            stall_left   = rsp_hold_req;
            rsp_hold_req = 0;
         end else if (stall_left == 0 && rsp_stall_pct != 0 &&
                      $urandom_range(0, 99) < rsp_stall_pct) begin
            stall_left = $urandom_range(1, 10);
         end
         if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Checking
   // ------------------------------------------------------------------------
   task automatic report_mismatch(input string msg);
      $display("mismatch @%0t: %s", $realtime, msg);
      error_count++;
   endtask

   task automatic check_field(input string name, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s got %h want %h", name, got, want));
   endtask

   // Sample between edges: a valid/ready pair seen here completes at the next edge
   initial begin
      refit_t got;
      refit_t want;
      forever begin
         @(negedge clock);
         if (!reset && rsp_tvalid && rsp_tready) begin
            got.box = rsp_tdata;
            got.sat = rsp_tuser;
            if (refit_expect_q.size() == 0) begin
               report_mismatch($sformatf("unexpected result %h", rsp_tdata));
            end else begin
               want = refit_expect_q.pop_front();
               check_field("min_x", got.box.min_x, want.box.min_x);
               check_field("min_y", got.box.min_y, want.box.min_y);
               check_field("min_z", got.box.min_z, want.box.min_z);
               check_field("max_x", got.box.max_x, want.box.max_x);
               check_field("max_y", got.box.max_y, want.box.max_y);
               check_field("max_z", got.box.max_z, want.box.max_z);
               check_field("saturated", {31'd0, got.sat}, {31'd0, want.sat});
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------

   // Reset values: identity rotation, no move
   task automatic test_reset_identity();
      send_box(make_box(0, 0, 0, 0, 0, 0));
      send_box(make_box(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX));
      send_box(make_box(32'sh0001_0000, -32'sh0002_8000, 32'sh7, -32'sh0001_0000,
                        32'sh0003_0000, -32'sh5));
      send_box(make_box(-32'sd1, COORD_MAX, 32'sd0, COORD_MIN, 32'sd1, -32'sd1));
      wait_idle();
   endtask

   // Fixed rotations, extreme registers, both saturation directions
   task automatic test_directed_transforms();
      // quarter turn about z, move by (10.5, -3, 0.25)
      set_config(32'd759250125, 32'd0, 32'd0, 32'd759250125,
                 32'h000A_8000, 32'hFFFD_0000, 32'h0000_4000, 1'b1);
      send_box(make_box(-32'sh0001_0000, 32'sh0, -32'sh0004_0000,
                        32'sh0002_0000, 32'sh0003_0000, 32'sh0004_0000));
      send_box(make_box(32'sh0005_0000, 32'sh0005_0000, 32'sh0005_0000,
                        -32'sh0005_0000, -32'sh0005_0000, -32'sh0005_0000));
      send_box(make_box(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX));
      wait_idle();
      // non-unit quaternion at the field extremes, move at the extremes
      set_config(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 1'b0);
      send_box(make_box(-32'sd3, 32'sd2, -32'sd1, 32'sd1, 32'sd4, 32'sd5));
      send_box(make_box(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX));
      send_box(make_box(0, 0, 0, 0, 0, 0));
      wait_idle();
      // identity with the largest positive move, then the largest negative move
      set_config(ROT_W_RESET, 32'd0, 32'd0, 32'd0,
                 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1);
      send_box(make_box(32'sd1, -32'sd1, 32'sd0, 32'sd2, 32'sd0, 32'sd0));
      send_box(make_box(COORD_MIN, COORD_MIN, COORD_MIN, -32'sd1, -32'sd1, -32'sd1));
      wait_idle();
      set_config(ROT_W_RESET, 32'd0, 32'd0, 32'd0,
                 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0);
      send_box(make_box(-32'sd1, -32'sd2, -32'sd3, 32'sd0, 32'sd1, 32'sd2));
      send_box(make_box(32'sd0, 32'sd0, 32'sd0, COORD_MAX, COORD_MAX, COORD_MAX));
      // half turn about x: w = 0
      wait_idle();
      set_config(32'd0, 32'h4000_0000, 32'd0, 32'd0,
                 32'd0, 32'd0, 32'd0, 1'b0);
      send_box(make_box(32'sh0001_0000, 32'sh0002_0000, 32'sh0003_0000,
                        32'sh0004_0000, 32'sh0005_0000, 32'sh0006_0000));
      send_box(make_box(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX));
      wait_idle();
   endtask

   // Hold the response side off long enough to fill the pipeline
   task automatic test_backpressure();
      req_gap_pct   = 0;
      rsp_stall_pct = 0;
      pick_config(0);
      apply_config(1'b0);
      rsp_hold_req = 300;
      repeat (40) send_box(rand_box($urandom_range(0, 2)));
      wait_idle();
   endtask

   // Random boxes under a series of random settings and idle rates
   task automatic test_random_boxes();
      int style;
      int box_style;
      for (int phase = 0; phase < 8; phase++) begin
         style = (phase < 4) ? phase : $urandom_range(0, 3);
         pick_config(style);
         apply_config($urandom_range(0, 1));
         case ($urandom_range(0, 3))
            0: req_gap_pct = 0;
            1: req_gap_pct = 10;
            2: req_gap_pct = 30;
            default: req_gap_pct = 60;
         endcase
         case ($urandom_range(0, 3))
            0: rsp_stall_pct = 0;
            1: rsp_stall_pct = 10;
            2: rsp_stall_pct = 30;
            default: rsp_stall_pct = 60;
         endcase
         for (int n = 0; n < 100; n++) begin
            box_style = $urandom_range(0, 9);
            send_box(rand_box(box_style < 6 ? 0 : (box_style < 9 ? 1 : 2)));
         end
         wait_idle();
      end
   endtask

   // Closing stretch at full rate on both sides
   task automatic test_full_rate();
      req_gap_pct   = 0;
      rsp_stall_pct = 0;
      pick_config(1);
      apply_config(1'b0);
      repeat (100) send_box(rand_box($urandom_range(0, 1)));
      wait_idle();
   endtask

   // ------------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------------
   initial begin
      xform_reg[REG_ROT_W] = ROT_W_RESET;
      for (int i = 1; i < NUM_REGS; i++) xform_reg[i] = 32'd0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_identity();
      test_directed_transforms();
      test_backpressure();
      test_random_boxes();
      test_full_rate();

      if (refit_expect_q.size() != 0)
         report_mismatch($sformatf("%0d results never arrived", refit_expect_q.size()));
      if (error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
